FILE: design/pppc_pkg.sv
package pppc_pkg;

	// Square root datapath: 48-bit radicand, 24-bit root, one root bit per cell.
	localparam int SQRT_IN_W = 48;
	localparam int ROOT_W    = 24;
	localparam int REM_W     = 26;

	// Multiplier fraction: 16 quotient bits, one bit per cell.
	localparam int Q_W       = 16;
	localparam int MAG_W     = Q_W + 1;

	// Register indexes on the configuration port.
	localparam logic REG_SETPOINT = 1'b0;
	localparam logic REG_GAIN     = 1'b1;

	// Quarter-wave sine table, Q1.15, one entry per degree.
	localparam logic [16:0] SIN_TAB [0:90] = '{
		17'd0,     17'd572,   17'd1144,  17'd1715,  17'd2286,  17'd2856,  17'd3425,
		17'd3993,  17'd4560,  17'd5126,  17'd5690,  17'd6252,  17'd6813,  17'd7371,
		17'd7927,  17'd8481,  17'd9032,  17'd9581,  17'd10126, 17'd10668, 17'd11208,
		17'd11743, 17'd12275, 17'd12804, 17'd13328, 17'd13849, 17'd14365, 17'd14877,
		17'd15384, 17'd15886, 17'd16384, 17'd16877, 17'd17364, 17'd17847, 17'd18324,
		17'd18795, 17'd19261, 17'd19720, 17'd20174, 17'd20622, 17'd21063, 17'd21498,
		17'd21926, 17'd22348, 17'd22763, 17'd23170, 17'd23571, 17'd23965, 17'd24351,
		17'd24730, 17'd25102, 17'd25466, 17'd25822, 17'd26170, 17'd26510, 17'd26842,
		17'd27166, 17'd27482, 17'd27789, 17'd28088, 17'd28378, 17'd28660, 17'd28932,
		17'd29197, 17'd29452, 17'd29698, 17'd29935, 17'd30163, 17'd30382, 17'd30592,
		17'd30792, 17'd30983, 17'd31164, 17'd31336, 17'd31499, 17'd31651, 17'd31795,
		17'd31928, 17'd32052, 17'd32166, 17'd32270, 17'd32365, 17'd32449, 17'd32524,
		17'd32588, 17'd32643, 17'd32688, 17'd32723, 17'd32748, 17'd32763, 17'd32768
	};

	// Per-word side information that rides along the cell chain.
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic zero;
		logic big;
		logic full_x;
		logic full_y;
	} pppc_flags_t;

endpackage

FILE: design/pppc_cell.sv
module pppc_cell
	import pppc_pkg::*;
#(
	parameter int SW     = 33,
	parameter bit DIV_EN = 1'b1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_i,
	input  pppc_flags_t          flags_i,
	input  logic [SQRT_IN_W-1:0] v_i,
	input  logic [REM_W-1:0]     rem_i,
	input  logic [ROOT_W-1:0]    root_i,
	input  logic [SW-1:0]        b_i,
	input  logic [SW-1:0]        rx_i,
	input  logic [SW-1:0]        ry_i,
	input  logic [Q_W-1:0]       qx_i,
	input  logic [Q_W-1:0]       qy_i,
	output logic                 vld_o,
	output pppc_flags_t          flags_o,
	output logic [SQRT_IN_W-1:0] v_o,
	output logic [REM_W-1:0]     rem_o,
	output logic [ROOT_W-1:0]    root_o,
	output logic [SW-1:0]        b_o,
	output logic [SW-1:0]        rx_o,
	output logic [SW-1:0]        ry_o,
	output logic [Q_W-1:0]       qx_o,
	output logic [Q_W-1:0]       qy_o
);

	logic                 vld_q;
	pppc_flags_t          flags_q;
	logic [SQRT_IN_W-1:0] v_q;
	logic [REM_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;
	logic [SW-1:0]        b_q, rx_q, ry_q;
	logic [Q_W-1:0]       qx_q, qy_q;

	logic [REM_W+1:0] rem_sh, trial;
	logic             take;
	logic [SW:0]      two_x, two_y;
	logic             ge_x, ge_y;

	// One restoring square root step: bring down two radicand bits.
	always_comb begin
		rem_sh = {rem_i, v_i[SQRT_IN_W-1 -: 2]};
		trial  = (REM_W+2)'({root_i, 2'b01});
		take   = rem_sh >= trial;
	end

	// One restoring division step for each axis fraction.
	always_comb begin
		two_x = {rx_i, 1'b0};
		two_y = {ry_i, 1'b0};
		ge_x  = two_x >= {1'b0, b_i};
		ge_y  = two_y >= {1'b0, b_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_q <= flags_i;
			v_q     <= {v_i[SQRT_IN_W-3:0], 2'b00};
			rem_q   <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q  <= {root_i[ROOT_W-2:0], take};
			b_q     <= b_i;
			if (DIV_EN) begin
				rx_q <= ge_x ? SW'(two_x - {1'b0, b_i}) : SW'(two_x);
				ry_q <= ge_y ? SW'(two_y - {1'b0, b_i}) : SW'(two_y);
				qx_q <= {qx_i[Q_W-2:0], ge_x};
				qy_q <= {qy_i[Q_W-2:0], ge_y};
			end else begin
				rx_q <= rx_i;
				ry_q <= ry_i;
				qx_q <= qx_i;
				qy_q <= qy_i;
			end
		end
	end

	assign vld_o   = vld_q;
	assign flags_o = flags_q;
	assign v_o     = v_q;
	assign rem_o   = rem_q;
	assign root_o  = root_q;
	assign b_o     = b_q;
	assign rx_o    = rx_q;
	assign ry_o    = ry_q;
	assign qx_o    = qx_q;
	assign qy_o    = qy_q;

endmodule

FILE: design/planar_position_p_controller.sv
// Channel  Handshake               Words carried
// input    in_valid / in_ready     quad_x, quad_y, target_x, target_y, heading_deg
// output   out_valid / out_ready   pitch_angle, roll_angle, distance
// config   APB psel/penable        distance_setpoint (0x0), gain (0x4)
//
// One word enters per cycle while in_ready is high; each word passes 32 register
// stages: five front stages (offset/trig, rotate products, rotate sum, squares,
// sum of squares), a chain of 24 cells giving one root bit each (the first 16 also
// give one fraction bit per axis), then reaction, final multiply and the output
// register.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// A stalled output freezes the whole pipeline, and in_ready drops for that cycle.
module planar_position_p_controller
	import pppc_pkg::*;
#(
	parameter int COORD_WIDTH    = 16,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [14:0] quad_x,
	input  logic signed [14:0] quad_y,
	input  logic signed [14:0] target_x,
	input  logic signed [14:0] target_y,
	input  logic signed [8:0]  heading_deg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pitch_angle,
	output logic signed [31:0] roll_angle,
	output logic [23:0]        distance,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CF    = TRIG_FRAC_BITS + 2;
	localparam int PW    = 16 + CF;
	localparam int SUMW  = PW + 1;
	localparam int WW    = ((SUMW > COORD_WIDTH) ? SUMW : COORD_WIDTH) + 1;
	localparam int SQW   = 2 * COORD_WIDTH;
	localparam int SW    = SQW + 1;
	localparam int SH    = 15 - TRIG_FRAC_BITS;
	localparam int NCELL = ROOT_W;

	localparam logic [17:0] TRIG_RND = (SH > 0) ? (18'd1 << ((SH > 0) ? SH - 1 : 0)) : 18'd0;
	localparam logic signed [WW-1:0] TRUNC_ADJ = WW'((64'd1 << TRIG_FRAC_BITS) - 64'd1);
	localparam logic signed [WW-1:0] SAT_HI    = WW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
	localparam logic signed [WW-1:0] SAT_LO    = -SAT_HI - WW'(1);

	// Signed sine of d degrees (0..359), reduced to the trig fraction width.
	function automatic logic signed [CF-1:0] trig(input logic [8:0] d);
		logic [6:0]            idx;
		logic                  neg;
		logic [17:0]           t;
		logic signed [CF-1:0]  m;
		if (d <= 9'd90) begin
			idx = d[6:0];
			neg = 1'b0;
		end else if (d <= 9'd180) begin
			idx = 7'(9'd180 - d);
			neg = 1'b0;
		end else if (d <= 9'd270) begin
			idx = 7'(d - 9'd180);
			neg = 1'b1;
		end else begin
			idx = 7'(9'd360 - d);
			neg = 1'b1;
		end
		t = ({1'b0, SIN_TAB[idx]} + TRIG_RND) >> SH;
		m = CF'(t);
		return neg ? -m : m;
	endfunction

	// Truncate toward zero by the trig fraction, then saturate to the coordinate width.
	function automatic logic signed [COORD_WIDTH-1:0] rot_fix(input logic signed [SUMW-1:0] v);
		logic signed [WW-1:0] w;
		w = WW'(v);
		if (w < 0) begin
			w = w + TRUNC_ADJ;
		end
		w = w >>> TRIG_FRAC_BITS;
		if (w > SAT_HI) begin
			w = SAT_HI;
		end else if (w < SAT_LO) begin
			w = SAT_LO;
		end
		return COORD_WIDTH'(w);
	endfunction

	// Configuration registers.
	logic [15:0] setpoint_q, gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= 16'd0;
			gain_q     <= 16'd256;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_SETPOINT: setpoint_q <= pwdata[15:0];
				REG_GAIN:     gain_q     <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GAIN) ? {16'd0, gain_q} : {16'd0, setpoint_q};

	// The whole pipeline advances together unless the output word is held.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: offset and trig coefficients.
	logic [9:0] hd_wrap, cd_wrap;
	logic [8:0] hd, cd;

	always_comb begin
		hd_wrap = {heading_deg[8], heading_deg} + (heading_deg[8] ? 10'd360 : 10'd0);
		hd      = hd_wrap[8:0];
		cd_wrap = {1'b0, hd} + 10'd90;
		cd      = (cd_wrap >= 10'd360) ? 9'(cd_wrap - 10'd360) : cd_wrap[8:0];
	end

	logic                 v_s1;
	logic signed [15:0]   dx_s1, dy_s1;
	logic signed [CF-1:0] sn_s1, cs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= 16'(target_x) - 16'(quad_x);
			dy_s1 <= 16'(target_y) - 16'(quad_y);
			sn_s1 <= trig(hd);
			cs_s1 <= trig(cd);
		end
	end

	// Stage 2: rotation products.
	logic                 v_s2;
	logic signed [PW-1:0] p_xc_s2, p_ys_s2, p_yc_s2, p_xs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_xc_s2 <= PW'(dx_s1) * PW'(cs_s1);
			p_ys_s2 <= PW'(dy_s1) * PW'(sn_s1);
			p_yc_s2 <= PW'(dy_s1) * PW'(cs_s1);
			p_xs_s2 <= PW'(dx_s1) * PW'(sn_s1);
		end
	end

	// Stage 3: rotated components.
	logic                          v_s3;
	logic signed [COORD_WIDTH-1:0] rx_s3, ry_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s3 <= rot_fix(SUMW'(p_xc_s2) + SUMW'(p_ys_s2));
			ry_s3 <= rot_fix(SUMW'(p_yc_s2) - SUMW'(p_xs_s2));
		end
	end

	// Stage 4: squares.
	logic           v_s4;
	logic [SQW-1:0] sx_s4, sy_s4;
	logic           neg_x_s4, neg_y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s4    <= SQW'(SQW'(rx_s3) * SQW'(rx_s3));
			sy_s4    <= SQW'(SQW'(ry_s3) * SQW'(ry_s3));
			neg_x_s4 <= rx_s3 < 0;
			neg_y_s4 <= ry_s3 < 0;
		end
	end

	// Stage 5: squared distance and its special cases.
	logic [SW-1:0]    s_sum;
	logic [SW+31:0]   s_wide;
	logic             v_s5;
	logic [SW-1:0]    s_s5, sx_s5, sy_s5;
	logic [31:0]      s_low_s5;
	pppc_flags_t      flags_s5;

	always_comb begin
		s_sum  = SW'(sx_s4) + SW'(sy_s4);
		s_wide = {32'd0, s_sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s5            <= s_sum;
			sx_s5           <= SW'(sx_s4);
			sy_s5           <= SW'(sy_s4);
			s_low_s5        <= s_wide[31:0];
			flags_s5.neg_x  <= neg_x_s4;
			flags_s5.neg_y  <= neg_y_s4;
			flags_s5.zero   <= s_sum == '0;
			flags_s5.big    <= s_wide[SW+31:32] != '0;
			flags_s5.full_x <= SW'(sx_s4) == s_sum;
			flags_s5.full_y <= SW'(sy_s4) == s_sum;
		end
	end

	// Cell chain: root bits and fraction bits.
	logic                 c_vld   [0:NCELL];
	pppc_flags_t          c_flags [0:NCELL];
	logic [SQRT_IN_W-1:0] c_v     [0:NCELL];
	logic [REM_W-1:0]     c_rem   [0:NCELL];
	logic [ROOT_W-1:0]    c_root  [0:NCELL];
	logic [SW-1:0]        c_b     [0:NCELL];
	logic [SW-1:0]        c_rx    [0:NCELL];
	logic [SW-1:0]        c_ry    [0:NCELL];
	logic [Q_W-1:0]       c_qx    [0:NCELL];
	logic [Q_W-1:0]       c_qy    [0:NCELL];

	assign c_vld[0]   = v_s5;
	assign c_flags[0] = flags_s5;
	assign c_v[0]     = {s_low_s5, 16'd0};
	assign c_rem[0]   = '0;
	assign c_root[0]  = '0;
	assign c_b[0]     = s_s5;
	assign c_rx[0]    = sx_s5;
	assign c_ry[0]    = sy_s5;
	assign c_qx[0]    = '0;
	assign c_qy[0]    = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		pppc_cell #(
			.SW     (SW),
			.DIV_EN (i < Q_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.vld_i   (c_vld[i]),
			.flags_i (c_flags[i]),
			.v_i     (c_v[i]),
			.rem_i   (c_rem[i]),
			.root_i  (c_root[i]),
			.b_i     (c_b[i]),
			.rx_i    (c_rx[i]),
			.ry_i    (c_ry[i]),
			.qx_i    (c_qx[i]),
			.qy_i    (c_qy[i]),
			.vld_o   (c_vld[i+1]),
			.flags_o (c_flags[i+1]),
			.v_o     (c_v[i+1]),
			.rem_o   (c_rem[i+1]),
			.root_o  (c_root[i+1]),
			.b_o     (c_b[i+1]),
			.rx_o    (c_rx[i+1]),
			.ry_o    (c_ry[i+1]),
			.qx_o    (c_qx[i+1]),
			.qy_o    (c_qy[i+1])
		);
	end

	// Stage 6: distance, multiplier magnitudes and reaction.
	pppc_flags_t        fl;
	logic [23:0]        dist_c;
	logic signed [24:0] err_c;
	logic signed [41:0] react_c;

	always_comb begin
		fl      = c_flags[NCELL];
		dist_c  = fl.big ? 24'hFFFFFF : c_root[NCELL];
		err_c   = $signed({1'b0, dist_c}) - $signed({1'b0, setpoint_q, 8'd0});
		react_c = 42'(err_c) * 42'($signed({1'b0, gain_q}));
	end

	logic             v_s6;
	logic [23:0]      dist_s6;
	logic [MAG_W-1:0] mp_s6, mr_s6;
	logic [40:0]      rmag_s6;
	logic             np_s6, nr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= c_vld[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_s6 <= dist_c;
			mp_s6   <= fl.zero ? '0 : (fl.full_y ? MAG_W'(1 << Q_W) : MAG_W'(c_qy[NCELL]));
			mr_s6   <= fl.zero ? '0 : (fl.full_x ? MAG_W'(1 << Q_W) : MAG_W'(c_qx[NCELL]));
			rmag_s6 <= react_c[41] ? 41'(-react_c) : 41'(react_c);
			np_s6   <= fl.neg_y ^ react_c[41];
			nr_s6   <= fl.neg_x ^ react_c[41];
		end
	end

	// Stage 7: angle magnitudes.
	logic        v_s7;
	logic [23:0] dist_s7;
	logic [57:0] pp_s7, pr_s7;
	logic        np_s7, nr_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_s7 <= dist_s6;
			pp_s7   <= 58'(mp_s6) * 58'(rmag_s6);
			pr_s7   <= 58'(mr_s6) * 58'(rmag_s6);
			np_s7   <= np_s6;
			nr_s7   <= nr_s6;
		end
	end

	// Sign and saturate a scaled magnitude to 32 bits.
	function automatic logic [31:0] angle_sat(input logic [57:0] p, input logic neg);
		logic [33:0] m;
		m = p[57:24];
		if (neg) begin
			return (m > 34'h080000000) ? 32'h80000000 : 32'(-m);
		end
		return (m > 34'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
	endfunction

	// Output register.
	logic        out_valid_q;
	logic [31:0] pitch_q, roll_q;
	logic [23:0] dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pitch_q <= angle_sat(pp_s7, np_s7);
			roll_q  <= angle_sat(pr_s7, nr_s7);
			dist_q  <= dist_s7;
		end
	end

	assign out_valid   = out_valid_q;
	assign pitch_angle = pitch_q;
	assign roll_angle  = roll_q;
	assign distance    = dist_q;

endmodule
